/* design/asl_pkg.sv */
// shared types, constants and helpers of the adaptive speed slew limiter
package asl_pkg;

    localparam int SPEED_WIDTH    = 20;
    localparam int CEIL_WIDTH     = SPEED_WIDTH - 1;
    localparam int CALC_WIDTH     = ((SPEED_WIDTH > 20) ? SPEED_WIDTH : 20) + 3;
    localparam int INIT_WIDTH     = 18;
    localparam int STEP_WIDTH     = 16;
    localparam int DECEL_WIDTH    = 14;
    localparam int CFG_DATA_WIDTH = 18;
    localparam int CFG_IDX_WIDTH  = 2;

    typedef logic signed [SPEED_WIDTH-1:0] t_speed;
    typedef logic        [CEIL_WIDTH-1:0]  t_ceil;
    typedef logic signed [CALC_WIDTH-1:0]  t_calc;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_INITIAL_LIMIT = 2'd0,
        CFG_LIMIT_STEP    = 2'd1,
        CFG_DECEL_STEP    = 2'd2
    } t_cfg_idx;

    localparam longint CEIL_MAX_L  = (longint'(1) << CEIL_WIDTH) - 1;
    localparam t_calc  CEIL_MAX    = t_calc'(CEIL_MAX_L);
    localparam t_calc  SPEED_MIN   = t_calc'(-CEIL_MAX_L - 1);

    // thresholds in quarter units
    localparam t_calc  LOW_BAND    = t_calc'(600);
    localparam t_calc  HIGH_BAND   = t_calc'(1600);
    localparam t_calc  LOW_GROWTH  = t_calc'(160);

    localparam logic [INIT_WIDTH-1:0]  RST_INIT_LIMIT = INIT_WIDTH'(400);
    localparam logic [STEP_WIDTH-1:0]  RST_LIMIT_STEP = STEP_WIDTH'(80);
    localparam logic [DECEL_WIDTH-1:0] RST_DECEL_STEP = DECEL_WIDTH'(20);

    // initial limit clipped to the ceiling range
    function automatic t_ceil sat_init(input logic [INIT_WIDTH-1:0] v);
        if (longint'(v) > CEIL_MAX_L) begin
            return t_ceil'(CEIL_MAX_L);
        end
        return t_ceil'(v);
    endfunction

endpackage

/* design/asl_cmd_if.sv */
// request channel carrying one speed command
interface asl_cmd_if;
    logic            valid;
    logic            ready;
    asl_pkg::t_speed speed_command;

    modport source (output valid, output speed_command, input ready);
    modport sink   (input valid, input speed_command, output ready);
endinterface

/* design/asl_out_if.sv */
// request channel carrying one smoothed speed
interface asl_out_if;
    logic            valid;
    logic            ready;
    asl_pkg::t_speed smoothed_speed;

    modport source (output valid, output smoothed_speed, input ready);
    modport sink   (input valid, input smoothed_speed, output ready);
endinterface

/* design/adaptive_speed_slew_limiter.sv */
// adaptive speed slew limiter: direction tracking, adaptive ceiling, decel limiting
//
//  channel     dir  handshake          payload
//  i_cmd       in   valid / ready      speed_command  (signed, quarter units)
//  o_smooth    out  valid / ready      smoothed_speed (signed, quarter units)
//  i_cfg_*     in   i_cfg_we only      i_cfg_idx, i_cfg_data
//
//  one request per cycle sustained while o_smooth.ready holds; an accepted command goes to the
//  input register, then its result to the result register, where o_smooth.valid rises
//  the whole step is combinational between the input register and the result register
//  state (direction, ceiling, previous output) updates when a request moves to the result
//  i_rst_n is synchronous active low: clears valids, state and config to reset values
//  a stalled result holds in the result register; the input register still fills
//  and i_cmd.ready drops only when both registers are full and o_smooth.ready is low
module adaptive_speed_slew_limiter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    asl_cmd_if.sink                               i_cmd,
    asl_out_if.source                             o_smooth,
    input  logic                                  i_cfg_we,
    input  logic [asl_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [asl_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data
);

    // configuration registers
    logic [asl_pkg::INIT_WIDTH-1:0]  r_init_limit;
    logic [asl_pkg::STEP_WIDTH-1:0]  r_limit_step;
    logic [asl_pkg::DECEL_WIDTH-1:0] r_decel_step;

    // pipeline registers
    logic            r_in_valid;
    asl_pkg::t_speed r_cmd;
    logic            r_out_valid;
    asl_pkg::t_speed r_out;

    // filter state
    logic            r_dir;
    asl_pkg::t_ceil  r_ceil;
    asl_pkg::t_speed r_prev;

    // next values
    logic            n_dir;
    asl_pkg::t_ceil  n_ceil;
    asl_pkg::t_speed n_out;

    logic adv;      // result register can take a new value
    logic s1_fire;  // input register moves into result register
    logic in_fire;

    assign adv     = !r_out_valid || o_smooth.ready;
    assign s1_fire = r_in_valid && adv;
    assign in_fire = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready             = !r_in_valid || adv;
    assign o_smooth.valid          = r_out_valid;
    assign o_smooth.smoothed_speed = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_limit <= asl_pkg::RST_INIT_LIMIT;
            r_limit_step <= asl_pkg::RST_LIMIT_STEP;
            r_decel_step <= asl_pkg::RST_DECEL_STEP;
        end else if (i_cfg_we) begin
            case (asl_pkg::t_cfg_idx'(i_cfg_idx))
                asl_pkg::CFG_INITIAL_LIMIT: begin
                    r_init_limit <= i_cfg_data[asl_pkg::INIT_WIDTH-1:0];
                end
                asl_pkg::CFG_LIMIT_STEP: begin
                    r_limit_step <= i_cfg_data[asl_pkg::STEP_WIDTH-1:0];
                end
                asl_pkg::CFG_DECEL_STEP: begin
                    r_decel_step <= i_cfg_data[asl_pkg::DECEL_WIDTH-1:0];
                end
                default: begin
                    // unknown index, ignored
                end
            endcase
        end
    end

    // one step of the limiter on the registered command
    always_comb begin
        asl_pkg::t_calc cmd_x;
        asl_pkg::t_calc last;
        asl_pkg::t_calc init_x;
        asl_pkg::t_calc init_raw;
        asl_pkg::t_calc ceil_cur;
        asl_pkg::t_calc mag_raw;
        asl_pkg::t_calc mag;
        asl_pkg::t_calc grow;
        asl_pkg::t_calc step;
        asl_pkg::t_calc ceil_sum;
        asl_pkg::t_calc q;
        asl_pkg::t_calc d;
        asl_pkg::t_calc d15;
        asl_pkg::t_calc d2;
        asl_pkg::t_calc o;
        logic           pos;
        logic           neg;
        logic           flip;

        cmd_x    = asl_pkg::t_calc'(r_cmd);
        last     = asl_pkg::t_calc'(r_prev);
        init_x   = asl_pkg::t_calc'(asl_pkg::sat_init(r_init_limit));
        init_raw = asl_pkg::t_calc'(r_init_limit);
        step     = asl_pkg::t_calc'(r_limit_step);

        pos  = (cmd_x > 0);
        neg  = (cmd_x < 0);
        flip = (pos && !r_dir) || (neg && r_dir);

        if (pos) begin
            n_dir = 1'b1;
        end else if (neg) begin
            n_dir = 1'b0;
        end else begin
            n_dir = r_dir;
        end

        // direction change restarts the ceiling
        ceil_cur = flip ? init_x : asl_pkg::t_calc'(r_ceil);
        mag_raw  = pos ? cmd_x : (neg ? -cmd_x : '0);

        // growth term chosen on the ceiling before its update
        if (ceil_cur < asl_pkg::LOW_BAND) begin
            grow = asl_pkg::LOW_GROWTH;
        end else if (ceil_cur < asl_pkg::HIGH_BAND) begin
            grow = step;
        end else begin
            grow = step <<< 1;
        end

        mag      = mag_raw;
        ceil_sum = init_x;
        if (mag_raw >= ceil_cur) begin
            mag      = ceil_cur;
            ceil_sum = ceil_cur + grow;
        end else if (mag_raw < init_raw) begin
            ceil_sum = init_x;
        end else begin
            ceil_sum = mag_raw + grow;
        end
        n_ceil = (ceil_sum > asl_pkg::CEIL_MAX) ? asl_pkg::t_ceil'(asl_pkg::CEIL_MAX)
                                                : asl_pkg::t_ceil'(ceil_sum);

        // decel terms, decel_step is in whole units
        q   = asl_pkg::t_calc'(r_decel_step);
        d   = q <<< 2;
        d15 = (q <<< 2) + (q <<< 1);
        d2  = q <<< 3;

        o = n_dir ? mag : -mag;

        if (n_dir) begin
            if (last < -d) begin
                o = last + d;
            end else if (last <= d15) begin
                if (last - o > q) begin
                    o = last - q;
                end
                if (o < 0) begin
                    o = '0;
                end
            end else if (last > asl_pkg::HIGH_BAND) begin
                if (last - o > d2) begin
                    o = last - d2;
                end
            end else if (last - o > d) begin
                o = last - d;
                if (o <= d15) begin
                    o = d15;
                end
            end
        end else begin
            if (last > d) begin
                o = last - d;
            end else if (last >= -d15) begin
                if (last - o < -q) begin
                    o = last + q;
                end
                if (o > 0) begin
                    o = '0;
                end
            end else if (last < -asl_pkg::HIGH_BAND) begin
                if (last - o < -d2) begin
                    o = last + d2;
                end
            end else if (last - o < -d) begin
                o = last + d;
                if (o >= -d15) begin
                    o = -d15;
                end
            end
        end

        // saturate to the speed field range
        if (o > asl_pkg::CEIL_MAX) begin
            n_out = asl_pkg::t_speed'(asl_pkg::CEIL_MAX);
        end else if (o < asl_pkg::SPEED_MIN) begin
            n_out = asl_pkg::t_speed'(asl_pkg::SPEED_MIN);
        end else begin
            n_out = asl_pkg::t_speed'(o);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_cmd.speed_command;
        end
    end

    // result register and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_dir       <= 1'b1;
            r_ceil      <= asl_pkg::sat_init(asl_pkg::RST_INIT_LIMIT);
            r_prev      <= '0;
        end else begin
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_dir       <= n_dir;
                r_ceil      <= n_ceil;
                r_prev      <= n_out;
            end else if (o_smooth.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    // checks
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

    a_prev_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (r_prev == r_out))
        else $error("previous output differs from delivered result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_cmd.ready)
        else $error("input stalled with empty result register");

    a_dir_follows_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !r_cmd[asl_pkg::SPEED_WIDTH-1] && (r_cmd != '0)) |=> r_dir)
        else $error("direction not rightward after positive command");

endmodule
